// File: hdl/lgg_pkg.sv
// Package with shared types and constants for the life grid generation step block.
package lgg_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int CFG_W   = 7;
    localparam int COORD_W = 6;
    localparam int COUNT_W = 4;

    localparam logic [COUNT_W-1:0] BIRTH_COUNT  = 4'd3;
    localparam logic [COUNT_W-1:0] SURVIVE_LOW  = 4'd2;
    localparam logic [COUNT_W-1:0] SURVIVE_HIGH = 4'd3;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2
    } t_opcode;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic step;
        logic wr;
        logic wr_val;
    } t_cell_ctrl;

    typedef struct packed {
        t_cell_ctrl          cell_ctrl;
        logic [COORD_W-1:0]  col;
    } t_row_ctrl;

endpackage

// File: hdl/life_grid_generation_step.sv
// Top level of the life grid generation step block: command control and the cell array.
// Each transaction (write cell, read cell, or one B3/S23 generation) is accepted when start is
// high and busy is low, is executed in the following cycle while busy is high, and its result
// is registered at the end of that execute cycle: it is on o_read_value and o_out_of_range
// with o_done high for exactly one cycle; the receiver cannot stall it. A new transaction can be
// accepted in the same cycle as that result, but not while busy is high: the command is first
// registered, then the whole cell array updates at once in the execute cycle. The grid is
// cleared by reset, and configuration writes never clear it.
module life_grid_generation_step #(
    parameter int MAX_WIDTH  = lgg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lgg_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_opcode,
    input  logic [lgg_pkg::COORD_W-1:0] i_column,
    input  logic [lgg_pkg::COORD_W-1:0] i_row,
    input  logic                        i_cell_value,
    output logic                        o_done,
    output logic                        o_read_value,
    output logic                        o_out_of_range,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [lgg_pkg::CFG_W-1:0]   i_cfg_data
);

    lgg_pkg::t_state             r_state;
    lgg_pkg::t_state             n_state;
    logic                        s_accept;
    logic                        s_exec;

    logic [lgg_pkg::CFG_W-1:0]   r_width;
    logic [lgg_pkg::CFG_W-1:0]   r_height;

    logic [1:0]                  r_op;
    logic [lgg_pkg::COORD_W-1:0] r_col;
    logic [lgg_pkg::COORD_W-1:0] r_row;
    logic                        r_val;

    logic                        r_done;
    logic                        r_read_value;
    logic                        r_oor;

    logic                        s_is_write;
    logic                        s_is_read;
    logic                        s_is_step;
    logic                        s_oor;
    logic                        s_read_bit;
    logic [MAX_WIDTH-1:0]        s_sel_row;
    logic [MAX_WIDTH-1:0]        s_col_en;
    logic [MAX_HEIGHT-1:0]       s_row_en;
    logic [MAX_WIDTH-1:0]        s_rows [MAX_HEIGHT];

    // Control state machine.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lgg_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = lgg_pkg::ST_EXEC;
                end
            end
            lgg_pkg::ST_EXEC: begin
                n_state = lgg_pkg::ST_IDLE;
            end
            default: begin
                n_state = lgg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            lgg_pkg::ST_IDLE: begin
                busy   = 1'b0;
                s_exec = 1'b0;
            end
            lgg_pkg::ST_EXEC: begin
                busy   = 1'b1;
                s_exec = 1'b1;
            end
            default: begin
                busy   = 1'b0;
                s_exec = 1'b0;
            end
        endcase
    end

    assign s_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lgg_pkg::ST_IDLE;
            r_width  <= lgg_pkg::CFG_W'(64);
            r_height <= lgg_pkg::CFG_W'(64);
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= s_exec;
            if (i_cfg_we) begin
                case (lgg_pkg::t_cfg_idx'(i_cfg_idx))
                    lgg_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                    lgg_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op  <= i_opcode;
            r_col <= i_column;
            r_row <= i_row;
            r_val <= i_cell_value;
        end
    end

    // Command decode for the execute cycle.
    always_comb begin
        s_is_write = 1'b0;
        s_is_read  = 1'b0;
        s_is_step  = 1'b0;
        case (lgg_pkg::t_opcode'(r_op))
            lgg_pkg::OP_WRITE: s_is_write = 1'b1;
            lgg_pkg::OP_READ:  s_is_read  = 1'b1;
            lgg_pkg::OP_STEP:  s_is_step  = 1'b1;
            default: ;
        endcase
    end

    assign s_oor = (s_is_write || s_is_read) &&
                   ((r_col >= lgg_pkg::COORD_W'(r_width)  && r_width[lgg_pkg::CFG_W-1] == 1'b0) ||
                    (r_row >= lgg_pkg::COORD_W'(r_height) && r_height[lgg_pkg::CFG_W-1] == 1'b0) ||
                    (32'(r_col) >= 32'(MAX_WIDTH)) ||
                    (32'(r_row) >= 32'(MAX_HEIGHT)));

    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col_en
        assign s_col_en[c] = 32'(r_width) > 32'(c);
    end

    for (genvar r = 0; r < MAX_HEIGHT; r++) begin : g_row
        lgg_pkg::t_row_ctrl   s_ctrl;
        logic [MAX_WIDTH-1:0] s_above;
        logic [MAX_WIDTH-1:0] s_below;

        assign s_row_en[r] = 32'(r_height) > 32'(r);

        always_comb begin
            s_ctrl.col              = r_col;
            s_ctrl.cell_ctrl.step   = s_exec && s_is_step;
            s_ctrl.cell_ctrl.wr     = s_exec && s_is_write && !s_oor && (32'(r_row) == 32'(r));
            s_ctrl.cell_ctrl.wr_val = r_val;
        end

        if (r == 0) begin : g_top
            assign s_above = '0;
        end else begin : g_upper
            assign s_above = s_rows[r-1];
        end

        if (r == MAX_HEIGHT - 1) begin : g_bot
            assign s_below = '0;
        end else begin : g_lower
            assign s_below = s_rows[r+1];
        end

        lgg_row #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_row (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (s_ctrl),
            .i_row_en (s_row_en[r]),
            .i_col_en (s_col_en),
            .i_above  (s_above),
            .i_below  (s_below),
            .o_bits   (s_rows[r])
        );
    end

    // Read path: the masked row bits equal the stored bits wherever the access is in range.
    always_comb begin
        s_sel_row = '0;
        for (int r = 0; r < MAX_HEIGHT; r++) begin
            if (32'(r_row) == 32'(r)) begin
                s_sel_row = s_rows[r];
            end
        end
    end

    always_comb begin
        s_read_bit = 1'b0;
        for (int c = 0; c < MAX_WIDTH; c++) begin
            if (32'(r_col) == 32'(c)) begin
                s_read_bit = s_sel_row[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_exec) begin
            r_read_value <= s_is_read && !s_oor && s_read_bit;
            r_oor        <= s_oor;
        end
    end

    assign o_done         = r_done;
    assign o_read_value   = r_read_value;
    assign o_out_of_range = r_oor;

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without an execute cycle");

    a_exec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("execute cycle lasted more than one cycle");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not enter execution");

    a_oor_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out_of_range) |-> !o_read_value)
        else $error("out-of-range access returned a live cell");

endmodule

// File: hdl/lgg_cell.sv
// One grid cell: holds its live bit and applies the B3/S23 rule to the count of its live neighbors.
module lgg_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lgg_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_en,
    input  logic [7:0]          i_nbr,
    output logic                o_alive
);

    logic                         r_alive;
    logic                         n_alive;
    logic [lgg_pkg::COUNT_W-1:0]  s_count;
    logic                         s_rule;

    always_comb begin
        s_count = '0;
        for (int k = 0; k < 8; k++) begin
            s_count = s_count + lgg_pkg::COUNT_W'(i_nbr[k]);
        end
    end

    always_comb begin
        if (r_alive) begin
            s_rule = (s_count >= lgg_pkg::SURVIVE_LOW) && (s_count <= lgg_pkg::SURVIVE_HIGH);
        end else begin
            s_rule = (s_count == lgg_pkg::BIRTH_COUNT);
        end
    end

    always_comb begin
        n_alive = r_alive;
        if (i_ctrl.wr) begin
            n_alive = i_ctrl.wr_val;
        end else if (i_ctrl.step && i_en) begin
            n_alive = s_rule;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
        end else begin
            r_alive <= n_alive;
        end
    end

    assign o_alive = r_alive;

endmodule

// File: hdl/lgg_row.sv
// One row of cells, exchanging masked live bits with the rows above and below.
module lgg_row #(
    parameter int MAX_WIDTH = lgg_pkg::MAX_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lgg_pkg::t_row_ctrl   i_ctrl,
    input  logic                 i_row_en,
    input  logic [MAX_WIDTH-1:0] i_col_en,
    input  logic [MAX_WIDTH-1:0] i_above,
    input  logic [MAX_WIDTH-1:0] i_below,
    output logic [MAX_WIDTH-1:0] o_bits
);

    logic [MAX_WIDTH-1:0] s_alive;
    logic [MAX_WIDTH+1:0] s_above_pad;
    logic [MAX_WIDTH+1:0] s_own_pad;
    logic [MAX_WIDTH+1:0] s_below_pad;

    // Cells outside the region in use are presented as dead to every neighbor.
    assign o_bits      = s_alive & i_col_en & {MAX_WIDTH{i_row_en}};
    assign s_above_pad = {1'b0, i_above, 1'b0};
    assign s_own_pad   = {1'b0, o_bits, 1'b0};
    assign s_below_pad = {1'b0, i_below, 1'b0};

    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_cell
        lgg_pkg::t_cell_ctrl s_cell_ctrl;
        logic [7:0]          s_nbr;

        always_comb begin
            s_cell_ctrl      = i_ctrl.cell_ctrl;
            s_cell_ctrl.wr   = i_ctrl.cell_ctrl.wr && (32'(i_ctrl.col) == 32'(c));
        end

        assign s_nbr = {s_above_pad[c+2:c], s_own_pad[c+2], s_own_pad[c],
                        s_below_pad[c+2:c]};

        lgg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (s_cell_ctrl),
            .i_en    (i_row_en && i_col_en[c]),
            .i_nbr   (s_nbr),
            .o_alive (s_alive[c])
        );
    end

endmodule

// File: tb/life_grid_generation_step_test.sv
// Self-checking testbench for the life grid generation step block with a cell-grid predictor.
`timescale 1ns / 100ps

module life_grid_generation_step_test;
    import lgg_pkg::*;

    localparam logic [1:0] OP_NOP    = 2'd3;
    localparam int         GRID_W    = MAX_WIDTH_DEF;
    localparam int         GRID_H    = MAX_HEIGHT_DEF;
    localparam int         RANDOM_CMDS = 1450;
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         SETTLE_CYCLES = 4;

    typedef struct {
        logic [1:0]         opcode;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               cell_value;
    } grid_cmd_t;

    typedef struct {
        logic read_value;
        logic out_of_range;
    } grid_outcome_t;

    // Tracks the grid and sizes, and holds the outcomes still owed by the block.
    class life_grid_tracker;
        bit [GRID_W-1:0] cells [GRID_H];
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        grid_outcome_t    owed_outcomes[$];
        int               mismatches;
        int               generations;
        int               out_of_range_hits;
        int               live_reads;

        function new();
            for (int r = 0; r < GRID_H; r++) begin
                cells[r] = '0;
            end
            width_reg  = 7'd64;
            height_reg = 7'd64;
            mismatches = 0;
            generations = 0;
            out_of_range_hits = 0;
            live_reads = 0;
        endfunction

        function int active_width();
            return (width_reg > GRID_W) ? GRID_W : int'(width_reg);
        endfunction

        function int active_height();
            return (height_reg > GRID_H) ? GRID_H : int'(height_reg);
        endfunction

        function void write_size(logic idx, logic [CFG_W-1:0] data);
            if (t_cfg_idx'(idx) == REG_WIDTH) begin
                width_reg = data;
            end else begin
                height_reg = data;
            end
        endfunction

        function int owed_count();
            return owed_outcomes.size();
        endfunction

        function void advance_generation();
            bit [GRID_W-1:0] next_cells [GRID_H];
            int h;
            int w;
            int live;
            int rr;
            int cc;
            h = active_height();
            w = active_width();
            next_cells = cells;
            for (int r = 0; r < h; r++) begin
                for (int c = 0; c < w; c++) begin
                    live = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            rr = r + dr;
                            cc = c + dc;
                            if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < h && cc < w)
                                live += cells[rr][cc];
                        end
                    end
                    if (cells[r][c])
                        next_cells[r][c] = (live >= SURVIVE_LOW && live <= SURVIVE_HIGH);
                    else
                        next_cells[r][c] = (live == BIRTH_COUNT);
                end
            end
            cells = next_cells;
            generations++;
        endfunction

        function void note_command(grid_cmd_t cmd);
            grid_outcome_t owed;
            owed.read_value   = 1'b0;
            owed.out_of_range = 1'b0;
            case (cmd.opcode)
                OP_WRITE, OP_READ: begin
                    if (cmd.column >= active_width() || cmd.row >= active_height()) begin
                        owed.out_of_range = 1'b1;
                        out_of_range_hits++;
                    end else if (cmd.opcode == OP_WRITE) begin
                        cells[cmd.row][cmd.column] = cmd.cell_value;
                    end else begin
                        owed.read_value = cells[cmd.row][cmd.column];
                        if (owed.read_value)
                            live_reads++;
                    end
                end
                OP_STEP: begin
                    advance_generation();
                end
                default: begin
                end
            endcase
            owed_outcomes = {owed_outcomes, owed};
        endfunction

        function void check_outcome(logic read_value, logic out_of_range);
            grid_outcome_t owed;
            if (owed_outcomes.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                mismatches++;
                return;
            end
            owed = owed_outcomes.pop_front();
            if (read_value !== owed.read_value) begin
                $error("read_value: expected %0d, actual %0d", owed.read_value, read_value);
                mismatches++;
            end
            if (out_of_range !== owed.out_of_range) begin
                $error("out_of_range: expected %0d, actual %0d", owed.out_of_range,
                       out_of_range);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_opcode = OP_WRITE;
    logic [COORD_W-1:0] i_column = '0;
    logic [COORD_W-1:0] i_row = '0;
    logic               i_cell_value = 1'b0;
    logic               o_done;
    logic               o_read_value;
    logic               o_out_of_range;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = REG_WIDTH;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    life_grid_tracker grid_tracker;
    int               cycle_count = 0;
    int               burst_left = 0;
    bit               gaps_on = 1'b0;
    int               commands_sent = 0;
    int               size_settings = 0;

    life_grid_generation_step u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_cell_value   (i_cell_value),
        .o_done         (o_done),
        .o_read_value   (o_read_value),
        .o_out_of_range (o_out_of_range),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Values sampled here are the ones from before the edge, since the block updates by NBA.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                grid_tracker.write_size(i_cfg_idx, i_cfg_data);
            if (start && !busy)
                grid_tracker.note_command('{i_opcode, i_column, i_row, i_cell_value});
            if (o_done)
                grid_tracker.check_outcome(o_read_value, o_out_of_range);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                     grid_tracker.owed_count());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic issue(logic [1:0] opcode, int column, int row, logic cell_value);
        if (gaps_on && burst_left == 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        start        = 1'b1;
        i_opcode     = opcode;
        i_column     = column[COORD_W-1:0];
        i_row        = row[COORD_W-1:0];
        i_cell_value = cell_value;
        do @(posedge i_clk); while (busy);
        if (burst_left > 0)
            burst_left--;
        if (opcode != OP_NOP)
            commands_sent++;
    endtask

    // Lower start and wait until every transaction has produced its result.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (grid_tracker.owed_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_size(t_cfg_idx idx, int value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    function automatic int pick_size();
        int k;
        k = $urandom_range(0, 15);
        case (k)
            0:       return 0;
            1:       return 64;
            2:       return $urandom_range(65, 127);
            3:       return 1;
            4, 5:    return $urandom_range(13, 64);
            default: return $urandom_range(2, 12);
        endcase
    endfunction

    function automatic int coord_in(int span);
        return (span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, 63);
    endfunction

    task automatic random_command();
        int pick;
        int w;
        int h;
        pick = $urandom_range(0, 99);
        w = grid_tracker.active_width();
        h = grid_tracker.active_height();
        if (pick < 30)
            issue(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
        else if (pick < 50)
            issue(OP_WRITE, coord_in(w), coord_in(h), $urandom_range(0, 9) < 6);
        else if (pick < 55)
            issue(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
        else if (pick < 80)
            issue(OP_READ, coord_in(w), coord_in(h), $urandom_range(0, 1));
        else if (pick < 88)
            issue(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
        else if (pick < 93)
            issue(OP_NOP, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
        else
            issue(OP_WRITE, coord_in(w), coord_in(h), 1'b0);
    endtask

    initial begin
        int seeds;
        int body;
        grid_tracker = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Full 64 by 64 grid straight out of reset: corners, a blinker, the unused opcode.
        issue(OP_WRITE, 63, 63, 1'b1);
        issue(OP_READ, 63, 63, 1'b0);
        issue(OP_WRITE, 0, 0, 1'b1);
        issue(OP_WRITE, 0, 0, 1'b0);
        issue(OP_READ, 0, 0, 1'b1);
        issue(OP_WRITE, 20, 5, 1'b1);
        issue(OP_WRITE, 21, 5, 1'b1);
        issue(OP_WRITE, 22, 5, 1'b1);
        issue(OP_STEP, 0, 0, 1'b0);
        issue(OP_READ, 21, 4, 1'b0);
        issue(OP_READ, 20, 5, 1'b0);
        issue(OP_NOP, 63, 63, 1'b1);
        issue(OP_STEP, 63, 63, 1'b1);
        issue(OP_READ, 63, 63, 1'b0);
        drain();

        // A 3 by 2 region: edges, accesses beyond it, and cells left outside it.
        set_size(REG_WIDTH, 3);
        set_size(REG_HEIGHT, 2);
        issue(OP_WRITE, 5, 1, 1'b1);
        issue(OP_READ, 3, 0, 1'b0);
        issue(OP_READ, 0, 2, 1'b0);
        issue(OP_WRITE, 0, 0, 1'b1);
        issue(OP_WRITE, 1, 0, 1'b1);
        issue(OP_WRITE, 2, 1, 1'b1);
        issue(OP_STEP, 0, 0, 1'b0);
        issue(OP_READ, 1, 1, 1'b0);
        drain();

        // An empty region, then sizes beyond the array, which clamp to it.
        set_size(REG_WIDTH, 0);
        issue(OP_WRITE, 0, 0, 1'b1);
        issue(OP_STEP, 0, 0, 1'b0);
        drain();
        set_size(REG_WIDTH, 127);
        set_size(REG_HEIGHT, 127);
        issue(OP_READ, 21, 5, 1'b0);
        issue(OP_READ, 1, 0, 1'b0);
        drain();
        size_settings = 4;

        // Random phases: seed a pattern in the region, then let it evolve amid reads and writes.
        while (commands_sent < RANDOM_CMDS - 120) begin
            set_size(REG_WIDTH, pick_size());
            set_size(REG_HEIGHT, pick_size());
            size_settings++;
            gaps_on = ($urandom_range(0, 3) != 0);
            burst_left = 0;
            seeds = grid_tracker.active_width() * grid_tracker.active_height() / 3;
            if (seeds > 30)
                seeds = 30;
            repeat (seeds) begin
                issue(OP_WRITE, coord_in(grid_tracker.active_width()),
                      coord_in(grid_tracker.active_height()), 1'b1);
            end
            body = $urandom_range(30, 90);
            repeat (body) random_command();
            drain();
        end

        $display("Sent %0d transactions over %0d grid sizes: %0d generations,", commands_sent,
                 size_settings, grid_tracker.generations);
        $display("%0d out-of-range accesses and %0d reads of live cells.",
                 grid_tracker.out_of_range_hits, grid_tracker.live_reads);
        if (grid_tracker.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/lgg_pkg.sv
hdl/lgg_cell.sv
hdl/lgg_row.sv
hdl/life_grid_generation_step.sv
tb/life_grid_generation_step_test.sv
